// ----- sv/irts_pkg.sv -----
package irts_pkg;

	localparam int unsigned SCALE_FRACTION_BITS_DEFAULT = 24;
	localparam int unsigned SCALE_W = 33;

	localparam logic [26:0] TICKS_PER_SECOND = 27'd100000000;
	localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;
	localparam logic [15:0] DAYS_TO_2000 = 16'd10957;
	localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;

	localparam logic REG_HOST_YEAR = 1'b0;
	localparam logic REG_SCALE = 1'b1;

	typedef struct packed {
		logic [6:0] year_of_century;
		logic [8:0] day_of_year;
		logic [4:0] hour_of_day;
		logic [5:0] minute_of_hour;
		logic [5:0] second_of_minute;
		logic [30:0] subsecond_count;
	} in_item_t;

	typedef struct packed {
		logic [58:0] time_code;
		logic year_was_filled;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic secs_en;
		logic ticks_en;
		logic lo_en;
		logic hi_en;
		logic out_load;
	} ctl_t;

	// days from 1970-01-01 to January first of year 2000+y
	function automatic logic [15:0] days_to_year(input logic [6:0] y);
		logic [15:0] d;
		logic [7:0] leaps;
		begin
			leaps = ({1'b0, y} + 8'd3) >> 2;
			d = DAYS_TO_2000 + 16'(y) * 16'(DAYS_COMMON_YEAR) + 16'(leaps);
			if (y >= 7'd101) begin
				d = d - 16'd1;
			end
			return d;
		end
	endfunction

endpackage

// ----- sv/irts_regs.sv -----
module irts_regs #(
	parameter int unsigned SCALE_FRACTION_BITS = irts_pkg::SCALE_FRACTION_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [6:0] host_year,
	output logic [irts_pkg::SCALE_W-1:0] scale
);
	import irts_pkg::*;

	logic [6:0] host_year_q;
	logic [SCALE_W-1:0] scale_q;
	logic wr_en;
	logic reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_year_q <= 7'd0;
			scale_q <= SCALE_W'(1) << SCALE_FRACTION_BITS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HOST_YEAR: host_year_q <= pwdata[6:0];
				REG_SCALE: scale_q <= SCALE_W'(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HOST_YEAR: prdata = {25'd0, host_year_q};
			REG_SCALE: prdata = scale_q[31:0];
			default: prdata = 32'd0;
		endcase
	end

	assign host_year = host_year_q;
	assign scale = scale_q;

endmodule

// ----- sv/irts_ctrl.sv -----
module irts_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	output irts_pkg::ctl_t ctl
);
	import irts_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SECS,
		ST_TICKS,
		ST_LO,
		ST_HI,
		ST_SUM
	} state_t;

	state_t state_q;
	logic out_valid_q;

	always_comb begin
		ctl.load = in_valid && (state_q == ST_IDLE);
		ctl.secs_en = (state_q == ST_SECS);
		ctl.ticks_en = (state_q == ST_TICKS);
		ctl.lo_en = (state_q == ST_LO);
		ctl.hi_en = (state_q == ST_HI);
		ctl.out_load = (state_q == ST_SUM) && (!out_valid_q || !out_stall);
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SECS;
				ST_SECS: state_q <= ST_TICKS;
				ST_TICKS: state_q <= ST_LO;
				ST_LO: state_q <= ST_HI;
				ST_HI: state_q <= ST_SUM;
				ST_SUM: if (ctl.out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_SECS))
		else $error("accepted item did not start work");
	a_sum_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && out_valid && out_stall) |=> (state_q == ST_SUM))
		else $error("result overwrote a waiting item");
	a_hi_to_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HI) |=> (state_q == ST_SUM))
		else $error("sequencer skipped the final sum");
	a_out_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_SUM))
		else $error("result appeared without a sum step");
`endif

endmodule

// ----- sv/irts_dp.sv -----
module irts_dp #(
	parameter int unsigned SCALE_FRACTION_BITS = irts_pkg::SCALE_FRACTION_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input irts_pkg::ctl_t ctl,
	input irts_pkg::in_item_t in_item,
	input logic [6:0] host_year,
	input logic [irts_pkg::SCALE_W-1:0] scale,
	output irts_pkg::out_item_t out_item
);
	import irts_pkg::*;

	logic [6:0] prev_year_q;
	logic [8:0] prev_day_q;
	logic seen_q;

	logic [6:0] year_q;
	logic filled_q;
	logic [8:0] day_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [5:0] second_q;
	logic [30:0] sub_q;
	logic [32:0] secs_q;
	logic [59:0] ticks_q;
	logic [46:0] plo_q;
	logic [63:0] prod_q;
	out_item_t out_q;

	logic [6:0] year_res;
	logic filled_res;
	logic [16:0] days_total;
	logic [32:0] secs_next;
	logic [59:0] code_sum;

	always_comb begin
		filled_res = (in_item.year_of_century == 7'd0);
		if (!filled_res) begin
			year_res = in_item.year_of_century;
		end else if (!seen_q) begin
			year_res = host_year;
		end else if (in_item.day_of_year == 9'd1 && prev_day_q >= DAYS_COMMON_YEAR) begin
			year_res = prev_year_q + 7'd1;
		end else begin
			year_res = prev_year_q;
		end
	end

	always_comb begin
		days_total = 17'(days_to_year(year_q)) + 17'(day_q) - 17'd1;
		secs_next = 33'(days_total) * 33'(SECONDS_PER_DAY) + 33'(hour_q) * 33'd3600
			+ 33'(minute_q) * 33'd60 + 33'(second_q);
		code_sum = ticks_q + 60'(prod_q >> SCALE_FRACTION_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_year_q <= 7'd0;
			prev_day_q <= 9'd0;
			seen_q <= 1'b0;
		end else if (ctl.load) begin
			prev_year_q <= year_res;
			prev_day_q <= in_item.day_of_year;
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			year_q <= year_res;
			filled_q <= filled_res;
			day_q <= in_item.day_of_year;
			hour_q <= in_item.hour_of_day;
			minute_q <= in_item.minute_of_hour;
			second_q <= in_item.second_of_minute;
			sub_q <= in_item.subsecond_count;
		end
		if (ctl.secs_en) begin
			secs_q <= secs_next;
		end
		if (ctl.ticks_en) begin
			ticks_q <= 60'(secs_q) * 60'(TICKS_PER_SECOND) + 60'(TICKS_PER_SECOND);
		end
		if (ctl.lo_en) begin
			plo_q <= 47'(sub_q) * 47'(scale[15:0]);
		end
		if (ctl.hi_en) begin
			prod_q <= ((64'(sub_q) * 64'(scale[SCALE_W-1:16])) << 16) + 64'(plo_q);
		end
		if (ctl.out_load) begin
			out_q.time_code <= code_sum[58:0];
			out_q.year_was_filled <= filled_q;
		end
	end

	assign out_item = out_q;

endmodule

// ----- sv/irig_stamp_to_timecode_unit.sv -----
// channel   direction  handshake                payload
// in        input      in_valid / in_stall      in_item  (irts_pkg::in_item_t)
// out       output     out_valid / out_stall    out_item (irts_pkg::out_item_t)
// config    input      APB psel/penable/pwrite  paddr[2:0], pwdata, prdata
//
// One item at a time: after acceptance the sequencer steps through days/seconds, the tick
// product, two subsecond partial products and the final sum, which loads the result.
// Input stalls until the result is loaded, so a new item waits until the previous one is done.
// A stalled result holds in the output register; the sequencer holds in its sum step.
// Reset clears year tracking, host_year to 0 and subsecond_scale to 1.0.
module irig_stamp_to_timecode_unit #(
	parameter int unsigned SCALE_FRACTION_BITS = irts_pkg::SCALE_FRACTION_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input irts_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output irts_pkg::out_item_t out_item,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import irts_pkg::*;

	ctl_t ctl;
	logic [6:0] host_year;
	logic [SCALE_W-1:0] scale;

	irts_regs #(
		.SCALE_FRACTION_BITS(SCALE_FRACTION_BITS)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.host_year(host_year),
		.scale(scale)
	);

	irts_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ctl(ctl)
	);

	irts_dp #(
		.SCALE_FRACTION_BITS(SCALE_FRACTION_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.in_item(in_item),
		.host_year(host_year),
		.scale(scale),
		.out_item(out_item)
	);

endmodule

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import irts_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int FRAC_BITS = SCALE_FRACTION_BITS_DEFAULT;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	in_item_t stamp_queue[$];
	out_item_t expected_codes[$];

	logic [6:0] cfg_host_year = 7'd0;
	logic [31:0] cfg_scale = 32'h0100_0000;
	logic [6:0] last_year = 7'd0;
	logic [8:0] last_day = 9'd0;
	logic stamp_seen = 1'b0;

	int send_gap_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	int hold_count = 0;
	logic holding;
	int cycle_count = 0;
	int mismatch_count = 0;
	int walk_year = 0;
	int walk_day = 1;

	irig_stamp_to_timecode_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned leap_days_before(input longint unsigned y);
		longint unsigned p;
		p = y - 1;
		return p / 4 - p / 100 + p / 400;
	endfunction

	function automatic longint unsigned epoch_days(input longint unsigned y);
		return (y - 1970) * 365 + leap_days_before(y) - leap_days_before(1970);
	endfunction

	function automatic out_item_t convert_stamp(input in_item_t s);
		out_item_t r;
		logic [6:0] yr;
		logic [63:0] secs;
		logic [63:0] frac_ticks;
		logic [63:0] code;
		yr = s.year_of_century;
		r.year_was_filled = 1'b0;
		if (yr == 7'd0) begin
			r.year_was_filled = 1'b1;
			if (!stamp_seen)
				yr = cfg_host_year;
			else if (s.day_of_year == 9'd1 && last_day >= DAYS_COMMON_YEAR)
				yr = last_year + 7'd1;
			else
				yr = last_year;
		end
		secs = (epoch_days(2000 + yr) + 64'(s.day_of_year)) * 64'(SECONDS_PER_DAY);
		secs = secs - 64'(SECONDS_PER_DAY) + 64'(s.hour_of_day) * 3600
			+ 64'(s.minute_of_hour) * 60 + 64'(s.second_of_minute);
		frac_ticks = (64'(s.subsecond_count) * 64'(cfg_scale)) >> FRAC_BITS;
		code = secs * 64'(TICKS_PER_SECOND) + frac_ticks + 64'(TICKS_PER_SECOND);
		r.time_code = code[58:0];
		last_year = yr;
		last_day = s.day_of_year;
		stamp_seen = 1'b1;
		return r;
	endfunction

	function automatic in_item_t stamp(input int yr, input int day, input int hr,
			input int mn, input int sec, input logic [30:0] sub);
		in_item_t s;
		s.year_of_century = 7'(yr);
		s.day_of_year = 9'(day);
		s.hour_of_day = 5'(hr);
		s.minute_of_hour = 6'(mn);
		s.second_of_minute = 6'(sec);
		s.subsecond_count = sub;
		return s;
	endfunction

	function automatic void queue_stamp(input in_item_t s);
		stamp_queue.insert(stamp_queue.size(), s);
	endfunction

	function automatic in_item_t random_stamp();
		in_item_t s;
		int days_in_year;
		if ($urandom_range(99) < 20) begin
			s = {$urandom(), $urandom()};
			return s;
		end
		days_in_year = (walk_year % 4 == 0) ? 366 : 365;
		if ($urandom_range(7) == 0)
			walk_day = $urandom_range(364, days_in_year);
		else
			walk_day = walk_day + $urandom_range(0, 20);
		if (walk_day > days_in_year) begin
			walk_day = 1;
			walk_year = (walk_year + 1) % 100;
		end
		s.year_of_century = ($urandom_range(2) != 0) ? 7'd0 : 7'(walk_year);
		s.day_of_year = 9'(walk_day);
		s.hour_of_day = 5'($urandom_range(0, 23));
		s.minute_of_hour = 6'($urandom_range(0, 59));
		s.second_of_minute = 6'($urandom_range(0, 60));
		s.subsecond_count = ($urandom_range(9) == 0) ? '1 : 31'($urandom());
		return s;
	endfunction

	task automatic report(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// stamp side: capture prediction on acceptance, then offer the next item
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_codes.insert(expected_codes.size(), convert_stamp(in_item));
			if (!in_valid || !in_stall) begin
				if (stamp_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					in_item <= stamp_queue.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!hold_req)
			hold_count <= 0;
		else if (hold_count < HOLD_CYCLES)
			hold_count <= hold_count + 1;
	end

	assign holding = hold_req && (hold_count < HOLD_CYCLES);

	always @(posedge clk) begin
		if (arst_n)
			out_stall <= holding || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_codes.size() == 0) begin
				report("time code with no stamp outstanding", out_item.time_code, 0);
			end else begin
				want = expected_codes.pop_front();
				if (out_item.time_code !== want.time_code)
					report("time_code", out_item.time_code, want.time_code);
				if (out_item.year_was_filled !== want.year_was_filled)
					report("year_was_filled", out_item.year_was_filled, want.year_was_filled);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic set_reg(input logic idx, input logic [31:0] value);
		logic [31:0] want;
		if (idx == REG_HOST_YEAR) begin
			cfg_host_year = value[6:0];
			want = {25'd0, value[6:0]};
		end else begin
			cfg_scale = value;
			want = value;
		end
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		if (prdata !== want)
			report("register read back", prdata, want);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (stamp_queue.size() != 0 || in_valid || expected_codes.size() != 0);
	endtask

	task automatic run_stamps(input int count, input int gap, input int stall);
		@(negedge clk);
		send_gap_pct = gap;
		stall_pct = stall;
		for (int i = 0; i < count; i++)
			queue_stamp(random_stamp());
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_reg(REG_HOST_YEAR, 32'd0);
		set_reg(REG_SCALE, 32'h0100_0000);

		// host year of zero, tracking, year roll-over, wrap past 127, odd fields
		queue_stamp(stamp(0, 1, 0, 0, 0, 31'd0));
		queue_stamp(stamp(0, 100, 12, 30, 30, 31'd12345));
		queue_stamp(stamp(99, 365, 23, 59, 60, 31'h7FFF_FFFF));
		queue_stamp(stamp(0, 1, 0, 0, 1, 31'd1));
		queue_stamp(stamp(0, 200, 5, 5, 5, 31'd100));
		queue_stamp(stamp(127, 366, 1, 2, 3, 31'd4));
		queue_stamp(stamp(0, 1, 0, 0, 0, 31'd0));
		queue_stamp(stamp(0, 0, 0, 0, 0, 31'd0));
		queue_stamp(stamp(0, 511, 31, 63, 63, 31'h7FFF_FFFF));
		queue_stamp(stamp(1, 1, 0, 0, 0, 31'd0));
		queue_stamp(stamp(0, 1, 0, 0, 0, 31'd7));
		queue_stamp(stamp(96, 366, 23, 59, 59, 31'h4000_0000));
		queue_stamp(stamp(0, 1, 0, 0, 0, 31'd0));
		queue_stamp(stamp(99, 364, 8, 0, 0, 31'd0));
		queue_stamp(stamp(0, 1, 8, 0, 0, 31'd0));
		queue_stamp(stamp(100, 60, 0, 0, 0, 31'd0));
		queue_stamp(stamp(101, 1, 0, 0, 0, 31'd0));
		queue_stamp(stamp(0, 365, 0, 0, 0, 31'd0));
		queue_stamp(stamp(0, 1, 0, 0, 0, 31'd0));
		queue_stamp(stamp(0, 366, 31, 0, 0, 31'h5555_5555));
		queue_stamp(stamp(42, 256, 16, 32, 32, 31'h2AAA_AAAA));
		drain();

		set_reg(REG_HOST_YEAR, 32'd99);
		set_reg(REG_SCALE, 32'hFFFF_FFFF);
		run_stamps(100, 47, 0);

		set_reg(REG_SCALE, 32'd0);
		run_stamps(100, 0, 47);

		set_reg(REG_HOST_YEAR, 32'($urandom_range(0, 99)));
		set_reg(REG_SCALE, $urandom());
		run_stamps(100, 35, 35);

		set_reg(REG_SCALE, 32'd1);
		run_stamps(50, 0, 0);

		// hold the result side off while stamps keep coming
		set_reg(REG_SCALE, 32'h0180_0000);
		@(negedge clk);
		hold_req = 1'b1;
		run_stamps(60, 0, 0);
		hold_req = 1'b0;

		set_reg(REG_SCALE, 32'h0100_0000);
		run_stamps(90, 35, 35);

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/irts_pkg.sv
sv/irts_regs.sv
sv/irts_ctrl.sv
sv/irts_dp.sv
sv/irig_stamp_to_timecode_unit.sv
tb/tb.sv
